>>> hw/rtl/dpu_pkg.sv
// Shared widths, register indexes and beat types for the depth unprojection block.
package dpu_pkg;

    localparam int DEPTH_W     = 16;
    localparam int COORD_W     = 12;
    localparam int STRIDE_W    = 8;
    localparam int INV_W       = 24;
    localparam int CENTER_W    = 16;
    localparam int XY_W        = 31;
    localparam int Z_W         = 19;
    localparam int CONF_W      = 2;
    localparam int INDEX_W     = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int OUT_DATA_W  = 112;

    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = 16'd10000;
    localparam logic [CONF_W-1:0]  CONF_HIGH   = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_SAMPLE_STRIDE = 3'd2,
        REG_INV_FOCAL_X   = 3'd3,
        REG_INV_FOCAL_Y   = 3'd4,
        REG_CENTER_X      = 3'd5,
        REG_CENTER_Y      = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0]  image_width;
        logic [COORD_W-1:0]  image_height;
        logic [STRIDE_W-1:0] sample_stride;
        logic [INV_W-1:0]    inv_focal_x;
        logic [INV_W-1:0]    inv_focal_y;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
    } cfg_t;

    // One kept pixel on its way from the front end to the math pipeline.
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [INDEX_W-1:0] index;
    } work_item_t;

endpackage

>>> hw/rtl/depth_pixel_unprojection.sv
// Top level of the depth pixel unprojection block: config registers and part wiring.
//
// Depth pixels (16-bit mm, raster order) come in on the s_ stream; every pixel on the
// stride grid with depth in 1..10000 mm leaves on the m_ stream as a pinhole point
// x = (col - cx) * d / fx, y = -(row - cy) * d / fy, z = -d, all in 1/16 mm, x and y
// rounded to nearest and saturated to 31 bits, with confidence 2 and its index in the
// frame. The block takes one pixel per clock while the queue has room and no grid
// realign pass runs. A point goes through the queue entry, offset stage, two multiply
// stages and output register before it shows on m_tvalid; dropped pixels are taken
// like kept ones but push nothing. The front end and the math pipeline are split by a
// four-entry queue so a stalled m_ side still lets pixels in until it fills.
// Writing sample_stride starts a remainder pass that realigns the grid phase to the
// current column and row; s_tready stays low during it. Other register writes take
// effect at once. Width and height of 0 act as 4096, a stride of 0 as 1. Counters are
// kept across size changes; a counter at or beyond a new size wraps at its next pixel.
// There is no post-reset clearing pass.
module depth_pixel_unprojection
    import dpu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // config write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // depth pixel beats
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DEPTH_W-1:0]     s_tdata,   // [15:0] depth
    // point beats
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata    // [30:0] point_x, [61:31] point_y,
                                              // [80:62] point_z, [82:81] confidence,
                                              // [106:83] point_index, [111:107] zero
);

    cfg_t       cfg_reg, cfg_next;
    logic       stride_wr;
    logic       q_push, q_full, q_valid, q_pop;
    work_item_t q_in, q_head;

    assign stride_wr = cfg_we && (cfg_index == REG_SAMPLE_STRIDE);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   cfg_next.image_width   = cfg_data[COORD_W-1:0];
                REG_IMAGE_HEIGHT:  cfg_next.image_height  = cfg_data[COORD_W-1:0];
                REG_SAMPLE_STRIDE: cfg_next.sample_stride = cfg_data[STRIDE_W-1:0];
                REG_INV_FOCAL_X:   cfg_next.inv_focal_x   = cfg_data[INV_W-1:0];
                REG_INV_FOCAL_Y:   cfg_next.inv_focal_y   = cfg_data[INV_W-1:0];
                REG_CENTER_X:      cfg_next.center_x      = cfg_data[CENTER_W-1:0];
                REG_CENTER_Y:      cfg_next.center_y      = cfg_data[CENTER_W-1:0];
                default:           cfg_next = cfg_reg;   // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width   <= COORD_W'(640);
            cfg_reg.image_height  <= COORD_W'(480);
            cfg_reg.sample_stride <= STRIDE_W'(1);
            cfg_reg.inv_focal_x   <= INV_W'(29077);
            cfg_reg.inv_focal_y   <= INV_W'(29077);
            cfg_reg.center_x      <= CENTER_W'(5112);
            cfg_reg.center_y      <= CENTER_W'(3832);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // raster tracking, grid test and depth filter
    dpu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .stride_wr  (stride_wr),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .depth      (s_tdata),
        .queue_full (q_full),
        .push       (q_push),
        .item       (q_in)
    );

    dpu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .valid     (q_valid),
        .pop       (q_pop),
        .head      (q_head)
    );

    // unprojection math and output register
    dpu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (q_valid),
        .item_pop   (q_pop),
        .item       (q_head),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata)
    );

endmodule

>>> hw/rtl/dpu_front.sv
// Front end: raster counters, stride grid phase, depth filter and point numbering.
module dpu_front
    import dpu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               stride_wr,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [DEPTH_W-1:0] depth,
    input  logic               queue_full,
    output logic               push,
    output work_item_t         item
);

    localparam int STEP_W = $clog2(COORD_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(COORD_W - 1);

    logic [COORD_W-1:0]  col_reg, col_next;
    logic [COORD_W-1:0]  row_reg, row_next;
    logic [STRIDE_W-1:0] col_phase_reg, col_phase_next;
    logic [STRIDE_W-1:0] row_phase_reg, row_phase_next;
    logic [INDEX_W-1:0]  index_reg, index_next;
    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [STRIDE_W-1:0] rem_col_reg, rem_col_next;
    logic [STRIDE_W-1:0] rem_row_reg, rem_row_next;

    logic [STRIDE_W-1:0] stride_eff;
    logic [COORD_W:0]    width_eff, height_eff;
    logic                accept, keep, col_wrap, row_wrap;
    logic [STRIDE_W-1:0] col_phase_inc, row_phase_inc;
    logic [STEP_W-1:0]   bit_sel;
    logic [STRIDE_W:0]   sh_col, sh_row;
    logic [STRIDE_W-1:0] rem_col_step, rem_row_step;

    // zero-valued size registers act as 4096, a zero stride acts as 1
    assign stride_eff = (cfg.sample_stride == '0) ? STRIDE_W'(1) : cfg.sample_stride;
    assign width_eff  = (cfg.image_width == '0) ? {1'b1, {COORD_W{1'b0}}}
                                                 : {1'b0, cfg.image_width};
    assign height_eff = (cfg.image_height == '0) ? {1'b1, {COORD_W{1'b0}}}
                                                  : {1'b0, cfg.image_height};

    assign in_ready = !busy_reg && !queue_full;
    assign accept   = in_valid && in_ready;

    assign keep = (col_phase_reg == '0) && (row_phase_reg == '0)
                  && (depth != '0) && (depth <= DEPTH_LIMIT);
    assign push = accept && keep;

    assign item.depth = depth;
    assign item.col   = col_reg;
    assign item.row   = row_reg;
    assign item.index = index_reg;

    assign col_wrap = ({1'b0, col_reg} + 1'b1) >= width_eff;
    assign row_wrap = ({1'b0, row_reg} + 1'b1) >= height_eff;

    assign col_phase_inc = ((col_phase_reg + 1'b1) == stride_eff) ? '0 : col_phase_reg + 1'b1;
    assign row_phase_inc = ((row_phase_reg + 1'b1) == stride_eff) ? '0 : row_phase_reg + 1'b1;

    // restoring remainder, one counter bit per cycle, after a stride change
    assign bit_sel      = LAST_STEP - step_reg;
    assign sh_col       = {rem_col_reg, col_reg[bit_sel]};
    assign sh_row       = {rem_row_reg, row_reg[bit_sel]};
    assign rem_col_step = (sh_col >= {1'b0, stride_eff}) ? STRIDE_W'(sh_col - {1'b0, stride_eff})
                                                         : STRIDE_W'(sh_col);
    assign rem_row_step = (sh_row >= {1'b0, stride_eff}) ? STRIDE_W'(sh_row - {1'b0, stride_eff})
                                                         : STRIDE_W'(sh_row);

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        index_next     = index_reg;
        busy_next      = busy_reg;
        step_next      = step_reg;
        rem_col_next   = rem_col_reg;
        rem_row_next   = rem_row_reg;

        if (accept)
        begin
            if (keep)
            begin
                index_next = index_reg + 1'b1;
            end
            if (col_wrap)
            begin
                col_next       = '0;
                col_phase_next = '0;
                if (row_wrap)
                begin
                    row_next       = '0;
                    row_phase_next = '0;
                    index_next     = '0;
                end
                else
                begin
                    row_next       = row_reg + 1'b1;
                    row_phase_next = row_phase_inc;
                end
            end
            else
            begin
                col_next       = col_reg + 1'b1;
                col_phase_next = col_phase_inc;
            end
        end

        if (stride_wr)
        begin
            busy_next    = 1'b1;
            step_next    = '0;
            rem_col_next = '0;
            rem_row_next = '0;
        end
        else if (busy_reg)
        begin
            rem_col_next = rem_col_step;
            rem_row_next = rem_row_step;
            step_next    = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next      = 1'b0;
                col_phase_next = rem_col_step;
                row_phase_next = rem_row_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
            index_reg     <= '0;
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            rem_col_reg   <= '0;
            rem_row_reg   <= '0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
            index_reg     <= index_next;
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            rem_col_reg   <= rem_col_next;
            rem_row_reg   <= rem_row_next;
        end
    end

    // grid phases are real remainders whenever pixels may be taken
    a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (col_phase_reg < stride_eff) && (row_phase_reg < stride_eff))
        else $error("grid phase out of range");

endmodule

>>> hw/rtl/dpu_queue.sv
// Short flip-flop queue of kept pixels between front end and math pipeline.
module dpu_queue
    import dpu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  work_item_t push_item,
    output logic       full,
    output logic       valid,
    input  logic       pop,
    output work_item_t head
);

    work_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;
    logic               do_pop;

    assign full   = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign valid  = (count_reg != '0);
    assign head   = entry_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

>>> hw/rtl/dpu_back.sv
// Math pipeline: offsets, two multiply stages, rounding and saturation, output register.
module dpu_back
    import dpu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  item_valid,
    output logic                  item_pop,
    input  work_item_t            item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    localparam int OFS_W  = CENTER_W + 2;
    localparam int P1_W   = CENTER_W + DEPTH_W;
    localparam int P2_W   = P1_W + INV_W;
    localparam int RND_SH = INV_W;
    localparam int Q_W    = P2_W + 1 - RND_SH;
    localparam int DZ_W   = DEPTH_W + 4;

    // round to nearest (ties away), then clamp to the signed output range
    function automatic logic [XY_W-1:0] round_sat(input logic [P2_W-1:0] prod, input logic neg);
        logic [P2_W:0]   sum;
        logic [Q_W-1:0]  q;
        logic [XY_W-1:0] res;
        sum = {1'b0, prod} + ((P2_W+1)'(1) << (RND_SH - 1));
        q   = sum[P2_W:RND_SH];
        if (neg)
        begin
            if (q > (Q_W)'(1) << (XY_W - 1))
            begin
                res = {1'b1, {(XY_W-1){1'b0}}};
            end
            else
            begin
                res = XY_W'(-q);
            end
        end
        else
        begin
            if (q > Q_W'({(XY_W-1){1'b1}}))
            begin
                res = {1'b0, {(XY_W-1){1'b1}}};
            end
            else
            begin
                res = XY_W'(q);
            end
        end
        return res;
    endfunction

    logic                a_v_reg, b_v_reg, c_v_reg, o_v_reg;
    logic                a_v_next, b_v_next, c_v_next, o_v_next;
    logic                o_free, c_mv, c_free, b_mv, b_free, a_mv, a_free;

    logic [CENTER_W-1:0] a_magx_reg, a_magy_reg;
    logic                a_negx_reg, a_negy_reg;
    logic [DEPTH_W-1:0]  a_depth_reg, b_depth_reg, c_depth_reg;
    logic [INDEX_W-1:0]  a_index_reg, b_index_reg, c_index_reg, o_index_reg;
    logic [P1_W-1:0]     b_px_reg, b_py_reg;
    logic                b_negx_reg, b_negy_reg, c_negx_reg, c_negy_reg;
    logic [P2_W-1:0]     c_px_reg, c_py_reg;
    logic [XY_W-1:0]     o_x_reg, o_y_reg;
    logic [Z_W-1:0]      o_z_reg;

    logic [OFS_W-1:0]    dx, dy;
    logic [DZ_W-1:0]     dz;
    logic [Z_W-1:0]      z_val;

    // stall chain: a stage moves when the one after it is free
    assign o_free   = !o_v_reg || out_ready;
    assign c_mv     = c_v_reg && o_free;
    assign c_free   = !c_v_reg || c_mv;
    assign b_mv     = b_v_reg && c_free;
    assign b_free   = !b_v_reg || b_mv;
    assign a_mv     = a_v_reg && b_free;
    assign a_free   = !a_v_reg || a_mv;
    assign item_pop = item_valid && a_free;

    assign a_v_next = item_pop ? 1'b1 : (a_mv ? 1'b0 : a_v_reg);
    assign b_v_next = a_mv ? 1'b1 : (b_mv ? 1'b0 : b_v_reg);
    assign c_v_next = b_mv ? 1'b1 : (c_mv ? 1'b0 : c_v_reg);
    assign o_v_next = c_mv ? 1'b1 : (out_ready ? 1'b0 : o_v_reg);

    // x offset is 16*col - cx; y uses cy - 16*row for the flipped axis
    assign dx = {2'b00, item.col, 4'b0000} - {2'b00, cfg.center_x};
    assign dy = {2'b00, cfg.center_y} - {2'b00, item.row, 4'b0000};

    assign dz    = {c_depth_reg, 4'b0000};
    assign z_val = (dz > DZ_W'(1) << (Z_W - 1)) ? {1'b1, {(Z_W-1){1'b0}}} : Z_W'(-dz);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= a_v_next;
            b_v_reg <= b_v_next;
            c_v_reg <= c_v_next;
            o_v_reg <= o_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            a_negx_reg  <= dx[OFS_W-1];
            a_negy_reg  <= dy[OFS_W-1];
            a_magx_reg  <= dx[OFS_W-1] ? CENTER_W'(-dx) : CENTER_W'(dx);
            a_magy_reg  <= dy[OFS_W-1] ? CENTER_W'(-dy) : CENTER_W'(dy);
            a_depth_reg <= item.depth;
            a_index_reg <= item.index;
        end
        if (a_mv)
        begin
            b_px_reg    <= a_magx_reg * a_depth_reg;
            b_py_reg    <= a_magy_reg * a_depth_reg;
            b_negx_reg  <= a_negx_reg;
            b_negy_reg  <= a_negy_reg;
            b_depth_reg <= a_depth_reg;
            b_index_reg <= a_index_reg;
        end
        if (b_mv)
        begin
            c_px_reg    <= b_px_reg * cfg.inv_focal_x;
            c_py_reg    <= b_py_reg * cfg.inv_focal_y;
            c_negx_reg  <= b_negx_reg;
            c_negy_reg  <= b_negy_reg;
            c_depth_reg <= b_depth_reg;
            c_index_reg <= b_index_reg;
        end
        if (c_mv)
        begin
            o_x_reg     <= round_sat(c_px_reg, c_negx_reg);
            o_y_reg     <= round_sat(c_py_reg, c_negy_reg);
            o_z_reg     <= z_val;
            o_index_reg <= c_index_reg;
        end
    end

    assign out_valid = o_v_reg;
    assign out_data  = {{(OUT_DATA_W - 2*XY_W - Z_W - CONF_W - INDEX_W){1'b0}},
                        o_index_reg, CONF_HIGH, o_z_reg, o_y_reg, o_x_reg};

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        c_v_reg && o_v_reg && !out_ready |=> c_v_reg)
        else $error("pipeline dropped a point under stall");

endmodule

>>> tb/depth_pixel_unprojection_test.sv
// Self-checking stream testbench for the depth pixel unprojection block.
module depth_pixel_unprojection_test;
    import dpu_pkg::*;

    // Write to an index past the register list; the block must ignore it.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    localparam longint POS_SAT       = (64'sd1 <<< 30) - 1;
    localparam longint NEG_SAT       = 64'sd1 <<< 30;
    localparam longint Z_SAT         = 64'sd1 <<< 18;
    localparam int     SETTLE_CYCLES = 24;    // queue + pipeline + margin for dropped pixels
    localparam int     LONG_HOLD     = 120;   // long output stall, enough to back up the queue
    localparam int     QUIET_LIMIT   = 2000;  // cycles with no beat or register write before giving up
    localparam int     RANDOM_PHASES = 10;
    localparam int     PHASE_PIXELS  = 103;

    // One point as it sits in m_tdata, point_x in the lowest bits.
    typedef struct packed {
        logic [INDEX_W-1:0] point_index;
        logic [CONF_W-1:0]  confidence;
        logic [Z_W-1:0]     point_z;
        logic [XY_W-1:0]    point_y;
        logic [XY_W-1:0]    point_x;
    } point_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [DEPTH_W-1:0]     s_tdata   = '0;   // [15:0] depth
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;          // [30:0] x, [61:31] y, [80:62] z,
                                              // [82:81] confidence, [106:83] index

    depth_pixel_unprojection dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: register copy, raster position, points in frame.
    // ------------------------------------------------------------------
    cfg_t        cfg_model = '{image_width: 12'd640, image_height: 12'd480,
                               sample_stride: 8'd1, inv_focal_x: 24'd29077,
                               inv_focal_y: 24'd29077, center_x: 16'd5112,
                               center_y: 16'd3832};
    int unsigned col_pos      = 0;
    int unsigned row_pos      = 0;
    int unsigned frame_points = 0;

    logic [DEPTH_W-1:0] pixel_q[$];        // depth pixels waiting for the driver
    point_t             pending_points[$]; // points predicted, not yet seen

    int pixels_pushed   = 0;
    int pixels_accepted = 0;
    int points_checked  = 0;
    int mismatches      = 0;
    int settings_used   = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    logic hold_armed    = 1'b0;

    // Pinhole scale of one axis: round half away from zero on the magnitude,
    // then clamp to the 31-bit signed range.
    function automatic longint scale_axis(input longint delta16, input longint unsigned depth,
                                          input longint unsigned inv);
        logic              neg;
        longint unsigned   mag;
        longint unsigned   prod;
        longint unsigned   q;
        neg  = delta16 < 0;
        mag  = neg ? -delta16 : delta16;
        prod = mag * depth * inv;
        q    = (prod + (64'd1 << 23)) >> 24;
        if (neg)
        begin
            if (q > NEG_SAT)
                q = NEG_SAT;
            return -longint'(q);
        end
        if (q > POS_SAT)
            q = POS_SAT;
        return longint'(q);
    endfunction

    // Advance the raster by one pixel and queue the point it yields, if any.
    function automatic void unproject_pixel(input logic [DEPTH_W-1:0] depth);
        int unsigned w;
        int unsigned h;
        int unsigned s;
        longint      dx;
        longint      dy;
        longint      px;
        longint      py;
        longint      pz;
        point_t      p;
        w = (cfg_model.image_width == 0) ? 4096 : cfg_model.image_width;
        h = (cfg_model.image_height == 0) ? 4096 : cfg_model.image_height;
        s = (cfg_model.sample_stride == 0) ? 1 : cfg_model.sample_stride;

        if ((col_pos % s == 0) && (row_pos % s == 0) && depth != 0 && depth <= DEPTH_LIMIT)
        begin
            dx = longint'(col_pos) * 16 - longint'(cfg_model.center_x);
            dy = longint'(row_pos) * 16 - longint'(cfg_model.center_y);
            px = scale_axis(dx, depth, cfg_model.inv_focal_x);
            py = scale_axis(-dy, depth, cfg_model.inv_focal_y);   // image y axis points down
            pz = -longint'(depth) * 16;
            if (pz < -Z_SAT)
                pz = -Z_SAT;
            p.point_x     = px[XY_W-1:0];
            p.point_y     = py[XY_W-1:0];
            p.point_z     = pz[Z_W-1:0];
            p.confidence  = CONF_HIGH;
            p.point_index = frame_points[INDEX_W-1:0];
            pending_points.insert(pending_points.size(), p);
            frame_points = (frame_points + 1) & 32'hFF_FFFF;
        end

        // raster wrap; a counter past a shrunken size wraps here too
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            if (row_pos + 1 >= h)
            begin
                row_pos      = 0;
                frame_points = 0;
            end
            else
                row_pos = (row_pos + 1) & 32'hFFF;
        end
        else
            col_pos = (col_pos + 1) & 32'hFFF;
    endfunction

    function automatic void check_field(input string field, input longint want_v,
                                        input longint got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued pixels, random gaps after a beat.
    // ------------------------------------------------------------------
    int send_gap = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                unproject_pixel(s_tdata);
                pixels_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pixel_q.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_q.pop_front();
                    if ($urandom_range(0, 99) < send_idle_pct)
                        send_gap = $urandom_range(1, 6);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each point beat and drives m_tready. One long stall
    // is taken once armed, timed here, so the input side backs up.
    // ------------------------------------------------------------------
    int     hold_left  = 0;
    int     stall_left = 0;
    logic   hold_done  = 1'b0;
    point_t got;
    point_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(point_t)-1:0];
                if (pending_points.size() == 0)
                begin
                    $error("point beat with no point expected: index %0d", got.point_index);
                    mismatches++;
                end
                else
                begin
                    want = pending_points.pop_front();
                    check_field("point_x", $signed(want.point_x), $signed(got.point_x));
                    check_field("point_y", $signed(want.point_y), $signed(got.point_y));
                    check_field("point_z", $signed(want.point_z), $signed(got.point_z));
                    check_field("confidence", want.confidence, got.confidence);
                    check_field("point_index", want.point_index, got.point_index);
                    points_checked++;
                end
                check_field("pad", 0, m_tdata[OUT_DATA_W-1:$bits(point_t)]);
            end

            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_armed && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < recv_idle_pct)
            begin
                stall_left = $urandom_range(1, 6) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: too long without any beat or register write.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Stalled for %0d cycles with %0d points outstanding",
                         quiet_cycles, pending_points.size());
                $display("TB_ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_pixel(input logic [DEPTH_W-1:0] depth);
        pixel_q.insert(pixel_q.size(), depth);
        pixels_pushed++;
    endfunction

    // Mostly valid depths; some zero, some above range, some anything.
    function automatic logic [DEPTH_W-1:0] random_depth();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return DEPTH_W'($urandom_range(1, DEPTH_LIMIT));
        else if (r < 80)
            return '0;
        else if (r < 90)
            return DEPTH_W'($urandom_range(DEPTH_LIMIT + 1, 16'hFFFF));
        return DEPTH_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // Small images mostly; extremes of every register now and then.
    function automatic cfg_t random_settings();
        cfg_t c;
        int   w_eff;
        case ($urandom_range(0, 9))
            0:       c.image_width = 12'd1;
            1:       c.image_width = 12'd4095;
            2:       c.image_width = 12'd0;
            default: c.image_width = COORD_W'($urandom_range(2, 40));
        endcase
        case ($urandom_range(0, 9))
            0:       c.image_height = 12'd1;
            1:       c.image_height = 12'd4095;
            2:       c.image_height = 12'd0;
            default: c.image_height = COORD_W'($urandom_range(1, 20));
        endcase
        case ($urandom_range(0, 9))
            0:       c.sample_stride = 8'd255;
            1:       c.sample_stride = 8'd0;
            2, 3, 4: c.sample_stride = STRIDE_W'($urandom_range(2, 4));
            default: c.sample_stride = 8'd1;
        endcase
        case ($urandom_range(0, 7))
            0:       c.inv_focal_x = 24'd1;
            1:       c.inv_focal_x = 24'hFF_FFFF;
            2:       c.inv_focal_x = 24'd0;
            3, 4:    c.inv_focal_x = INV_W'($urandom_range(1, 24'hFF_FFFF));
            default: c.inv_focal_x = INV_W'($urandom_range(10000, 60000));
        endcase
        case ($urandom_range(0, 7))
            0:       c.inv_focal_y = 24'd1;
            1:       c.inv_focal_y = 24'hFF_FFFF;
            2:       c.inv_focal_y = 24'd0;
            3, 4:    c.inv_focal_y = INV_W'($urandom_range(1, 24'hFF_FFFF));
            default: c.inv_focal_y = INV_W'($urandom_range(10000, 60000));
        endcase
        w_eff = (c.image_width == 0) ? 4095 : c.image_width;
        case ($urandom_range(0, 7))
            0:       c.center_x = 16'd0;
            1:       c.center_x = 16'hFFFF;
            2, 3:    c.center_x = CENTER_W'($urandom_range(0, 16'hFFFF));
            default: c.center_x = CENTER_W'($urandom_range(0, 16 * w_eff));
        endcase
        case ($urandom_range(0, 7))
            0:       c.center_y = 16'd0;
            1:       c.center_y = 16'hFFFF;
            2, 3:    c.center_y = CENTER_W'($urandom_range(0, 16'hFFFF));
            default: c.center_y = CENTER_W'($urandom_range(0, 320));
        endcase
        return c;
    endfunction

    // Wait until every pixel is in and every point out, then let any
    // dropped pixels still in flight clear the pipeline.
    task automatic wait_idle();
        while (pixels_accepted != pixels_pushed || pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write every register; stride goes last since it kicks off the grid
    // realign pass. The unused index gets junk that must be ignored.
    task automatic apply_settings(input cfg_t target);
        logic [CFG_INDEX_W-1:0] order [8];
        logic [CFG_DATA_W-1:0]  value;
        order = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_INV_FOCAL_X, REG_INV_FOCAL_Y,
                  REG_CENTER_X, REG_CENTER_Y, REG_UNUSED, REG_SAMPLE_STRIDE};
        foreach (order[i])
        begin
            case (order[i])
                REG_IMAGE_WIDTH:   value = CFG_DATA_W'(target.image_width);
                REG_IMAGE_HEIGHT:  value = CFG_DATA_W'(target.image_height);
                REG_SAMPLE_STRIDE: value = CFG_DATA_W'(target.sample_stride);
                REG_INV_FOCAL_X:   value = target.inv_focal_x;
                REG_INV_FOCAL_Y:   value = target.inv_focal_y;
                REG_CENTER_X:      value = CFG_DATA_W'(target.center_x);
                REG_CENTER_Y:      value = CFG_DATA_W'(target.center_y);
                default:           value = CFG_DATA_W'($urandom_range(0, 24'hFF_FFFF));
            endcase
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= value;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_model = target;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        cfg_t target;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings, depth edges: invalid zero, 1, max, one past max,
        // all ones, alternating bits, a plain value.
        queue_pixel(16'd0);
        queue_pixel(16'd1);
        queue_pixel(DEPTH_LIMIT);
        queue_pixel(DEPTH_LIMIT + 16'd1);
        queue_pixel(16'hFFFF);
        queue_pixel(16'h5555);
        queue_pixel(16'd9999);
        wait_idle();
        settings_used++;

        // 3x2 image entered with the column already past the new width:
        // wraps, frame restart, extreme focal and centre values.
        apply_settings('{image_width: 12'd3, image_height: 12'd2, sample_stride: 8'd1,
                         inv_focal_x: 24'hFF_FFFF, inv_focal_y: 24'd1,
                         center_x: 16'd0, center_y: 16'hFFFF});
        queue_pixel(16'd10000);
        queue_pixel(16'd1);
        queue_pixel(16'd10000);
        queue_pixel(16'd8191);
        queue_pixel(16'd10000);
        queue_pixel(16'd5000);
        queue_pixel(16'h8000);
        wait_idle();

        // Zero size acts as 4096, zero stride as 1, zero reciprocal gives 0.
        apply_settings('{image_width: 12'd0, image_height: 12'd0, sample_stride: 8'd0,
                         inv_focal_x: 24'd0, inv_focal_y: 24'd0,
                         center_x: 16'hFFFF, center_y: 16'd0});
        queue_pixel(16'd10000);
        queue_pixel(16'd1);
        queue_pixel(16'd300);
        wait_idle();

        // Stride 2 on a 10x5 image with the usual intrinsics.
        apply_settings('{image_width: 12'd10, image_height: 12'd5, sample_stride: 8'd2,
                         inv_focal_x: 24'd29077, inv_focal_y: 24'd29077,
                         center_x: 16'd80, center_y: 16'd40});
        repeat (6) queue_pixel(random_depth());
        wait_idle();

        // 1x1 image with the widest stride: every pixel is a new frame.
        apply_settings('{image_width: 12'd1, image_height: 12'd1, sample_stride: 8'd255,
                         inv_focal_x: 24'd12345, inv_focal_y: 24'd54321,
                         center_x: 16'd7, center_y: 16'd9});
        repeat (3) queue_pixel(16'd4000);
        wait_idle();

        // Random phases; the second one carries the long output stall, the
        // last one runs without any idling.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            target = random_settings();
            if (ph == 1)
                target.sample_stride = 8'd1;
            if (ph == RANDOM_PHASES - 1)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       send_idle_pct = 0;
                    1:       send_idle_pct = 15;
                    default: send_idle_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0:       recv_idle_pct = 0;
                    1:       recv_idle_pct = 15;
                    default: recv_idle_pct = 40;
                endcase
            end
            apply_settings(target);
            repeat (PHASE_PIXELS) queue_pixel(random_depth());
            if (ph == 1)
                hold_armed <= 1'b1;
            wait_idle();
        end

        if (pending_points.size() != 0)
        begin
            $error("%0d expected points never came out", pending_points.size());
            mismatches++;
        end

        $display("Sent %0d depth pixels under %0d register settings, sizes 1 to 4096,",
                 pixels_accepted, settings_used);
        $display("strides 0 to 255, with one long output stall; %0d points checked.",
                 points_checked);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> depth_pixel_unprojection.f
hw/rtl/dpu_pkg.sv
hw/rtl/dpu_front.sv
hw/rtl/dpu_queue.sv
hw/rtl/dpu_back.sv
hw/rtl/depth_pixel_unprojection.sv
tb/depth_pixel_unprojection_test.sv
